/* rtl/bms_pkg.sv */
`default_nettype none

package bms_pkg;

    // APB address: 7 registers, 4 bytes apart
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_BEEP_HZ       = 3'd0;
    localparam logic [2:0] REG_ALARM_REPEATS = 3'd1;
    localparam logic [2:0] REG_RING_REPEATS  = 3'd2;
    localparam logic [2:0] REG_RING_NOTE_A   = 3'd3;
    localparam logic [2:0] REG_RING_NOTE_B   = 3'd4;
    localparam logic [2:0] REG_RING_NOTE_C   = 3'd5;
    localparam logic [2:0] REG_RING_NOTE_D   = 3'd6;

    // Register reset values
    localparam logic [15:0] RST_BEEP_HZ       = 16'd4000;
    localparam logic [7:0]  RST_ALARM_REPEATS = 8'd5;
    localparam logic [7:0]  RST_RING_REPEATS  = 8'd50;
    localparam logic [15:0] RST_RING_NOTE_A   = 16'd2093;
    localparam logic [15:0] RST_RING_NOTE_B   = 16'd2349;
    localparam logic [15:0] RST_RING_NOTE_C   = 16'd2637;
    localparam logic [15:0] RST_RING_NOTE_D   = 16'd2794;

    // Note durations in ms
    localparam logic [9:0] DUR_RING_LONG  = 10'd30;
    localparam logic [9:0] DUR_RING_SHORT = 10'd10;
    localparam logic [9:0] DUR_BEEP       = 10'd40;
    localparam logic [9:0] DUR_PAT0_GAP   = 10'd840;
    localparam logic [9:0] DUR_PAT1_GAP   = 10'd720;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        bell_button;
        logic        bell_request;
        logic        alarm_request;
    } t_in_beat;

    typedef struct packed {
        logic        tone_on;
        logic [15:0] tone_hz;
        logic        tone_changed;
    } t_out_beat;

    typedef struct packed {
        logic [15:0]      beep_hz;
        logic [7:0]       alarm_repeats;
        logic [7:0]       ring_repeats;
        logic [3:0][15:0] ring_note;
    } t_cfg;

    function automatic logic [9:0] ring_dur(input logic [1:0] idx);
        return idx[0] ? DUR_RING_SHORT : DUR_RING_LONG;
    endfunction

    function automatic logic [9:0] pat0_dur(input logic [1:0] idx);
        return (idx == 2'd3) ? DUR_PAT0_GAP : DUR_BEEP;
    endfunction

    function automatic logic [9:0] pat1_dur(input logic [2:0] idx);
        return (idx == 3'd7) ? DUR_PAT1_GAP : DUR_BEEP;
    endfunction

endpackage

`default_nettype wire

/* rtl/bms_cfg_regs.sv */
`default_nettype none

module bms_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bms_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [bms_pkg::DATA_W-1:0]  pwdata,
    output logic      [bms_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output bms_pkg::t_cfg                    o_cfg
);
    import bms_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.beep_hz       <= RST_BEEP_HZ;
            r_cfg.alarm_repeats <= RST_ALARM_REPEATS;
            r_cfg.ring_repeats  <= RST_RING_REPEATS;
            r_cfg.ring_note[0]  <= RST_RING_NOTE_A;
            r_cfg.ring_note[1]  <= RST_RING_NOTE_B;
            r_cfg.ring_note[2]  <= RST_RING_NOTE_C;
            r_cfg.ring_note[3]  <= RST_RING_NOTE_D;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BEEP_HZ:       r_cfg.beep_hz       <= pwdata[15:0];
                REG_ALARM_REPEATS: r_cfg.alarm_repeats <= pwdata[7:0];
                REG_RING_REPEATS:  r_cfg.ring_repeats  <= pwdata[7:0];
                REG_RING_NOTE_A:   r_cfg.ring_note[0]  <= pwdata[15:0];
                REG_RING_NOTE_B:   r_cfg.ring_note[1]  <= pwdata[15:0];
                REG_RING_NOTE_C:   r_cfg.ring_note[2]  <= pwdata[15:0];
                REG_RING_NOTE_D:   r_cfg.ring_note[3]  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BEEP_HZ:       prdata = {16'd0, r_cfg.beep_hz};
            REG_ALARM_REPEATS: prdata = {24'd0, r_cfg.alarm_repeats};
            REG_RING_REPEATS:  prdata = {24'd0, r_cfg.ring_repeats};
            REG_RING_NOTE_A:   prdata = {16'd0, r_cfg.ring_note[0]};
            REG_RING_NOTE_B:   prdata = {16'd0, r_cfg.ring_note[1]};
            REG_RING_NOTE_C:   prdata = {16'd0, r_cfg.ring_note[2]};
            REG_RING_NOTE_D:   prdata = {16'd0, r_cfg.ring_note[3]};
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/bms_step.sv */
`default_nettype none

module bms_step (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire bms_pkg::t_in_beat i_in_beat,
    input  wire bms_pkg::t_cfg     i_cfg,
    output bms_pkg::t_out_beat     o_result
);
    import bms_pkg::*;

    logic        r_bell_active, n_bell_active;
    logic        r_alarm_active, n_alarm_active;
    logic [31:0] r_note_start, n_note_start;
    logic [2:0]  r_note_index, n_note_index;
    logic [1:0]  r_pattern_index, n_pattern_index;
    logic [7:0]  r_repeat_count, n_repeat_count;
    logic        r_last_on, n_last_on;
    logic [15:0] r_last_hz, n_last_hz;

    logic        bell, alarm, start;
    logic [31:0] ns_eff, elapsed;
    logic [2:0]  ni_eff;
    logic [1:0]  pi_eff;
    logic [7:0]  rc_eff, rc_inc;
    logic        exhausted, advance, last_note;
    logic [9:0]  dur;
    logic        on;
    logic [15:0] hz;

    assign bell   = i_in_beat.bell_button | i_in_beat.bell_request;
    assign alarm  = i_in_beat.alarm_request;
    // a mode entered from its cleared flag starts over at this tick's time
    assign start  = alarm ? !r_alarm_active : (bell && !r_bell_active);
    assign ns_eff = start ? i_in_beat.now_ms : r_note_start;
    assign ni_eff = start ? 3'd0 : r_note_index;
    assign pi_eff = start ? 2'd0 : r_pattern_index;
    assign rc_eff = start ? 8'd0 : r_repeat_count;
    assign rc_inc = rc_eff + 8'd1;
    assign elapsed = i_in_beat.now_ms - ns_eff;   // wraps mod 2^32
    assign advance = elapsed > {22'd0, dur};

    always_comb begin
        if (alarm) begin
            exhausted = pi_eff[1] || (rc_eff >= i_cfg.alarm_repeats)
                        || ((pi_eff == 2'd0) && ni_eff[2]);
            dur       = (pi_eff == 2'd0) ? pat0_dur(ni_eff[1:0]) : pat1_dur(ni_eff);
            last_note = (pi_eff == 2'd0) ? (ni_eff == 3'd3) : (ni_eff == 3'd7);
        end else begin
            exhausted = ni_eff[2] || (rc_eff >= i_cfg.ring_repeats);
            dur       = ring_dur(ni_eff[1:0]);
            last_note = (ni_eff[1:0] == 2'd3);
        end
    end

    always_comb begin
        n_bell_active   = r_bell_active;
        n_alarm_active  = r_alarm_active;
        n_note_start    = ns_eff;
        n_note_index    = ni_eff;
        n_pattern_index = pi_eff;
        n_repeat_count  = rc_eff;
        on              = 1'b0;
        hz              = 16'd0;

        if (alarm) begin
            n_alarm_active = 1'b1;
            on = 1'b1;
            if (!exhausted && advance) begin
                n_note_start = i_in_beat.now_ms;
                if (last_note) begin
                    // pass done; move to next pattern when count reached
                    n_note_index = 3'd0;
                    if (rc_inc >= i_cfg.alarm_repeats) begin
                        n_pattern_index = pi_eff + 2'd1;
                        n_repeat_count  = 8'd0;
                    end else begin
                        n_repeat_count = rc_inc;
                    end
                end else begin
                    n_note_index = ni_eff + 3'd1;
                    on = ni_eff[0];   // odd slots are gaps
                end
            end else if (!exhausted) begin
                on = !ni_eff[0];
            end
            hz = on ? i_cfg.beep_hz : 16'd0;
        end else if (bell) begin
            n_bell_active = 1'b1;
            if (!exhausted) begin
                on = 1'b1;
                if (advance) begin
                    n_note_start = i_in_beat.now_ms;
                    if (last_note) begin
                        n_note_index   = 3'd0;
                        n_repeat_count = rc_inc;
                        on = !(rc_inc >= i_cfg.ring_repeats);
                    end else begin
                        n_note_index = ni_eff + 3'd1;
                    end
                end
            end
            hz = on ? i_cfg.ring_note[n_note_index[1:0]] : 16'd0;
        end else begin
            n_bell_active  = 1'b0;
            n_alarm_active = 1'b0;
        end

        n_last_on = on;
        n_last_hz = hz;
    end

    assign o_result.tone_on      = on;
    assign o_result.tone_hz      = hz;
    assign o_result.tone_changed = (on != r_last_on) || (hz != r_last_hz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bell_active   <= 1'b0;
            r_alarm_active  <= 1'b0;
            r_note_start    <= 32'd0;
            r_note_index    <= 3'd0;
            r_pattern_index <= 2'd0;
            r_repeat_count  <= 8'd0;
            r_last_on       <= 1'b0;
            r_last_hz       <= 16'd0;
        end else if (i_accept) begin
            r_bell_active   <= n_bell_active;
            r_alarm_active  <= n_alarm_active;
            r_note_start    <= n_note_start;
            r_note_index    <= n_note_index;
            r_pattern_index <= n_pattern_index;
            r_repeat_count  <= n_repeat_count;
            r_last_on       <= n_last_on;
            r_last_hz       <= n_last_hz;
        end
    end

endmodule

`default_nettype wire

/* rtl/bms_out_buf.sv */
`default_nettype none

module bms_out_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire bms_pkg::t_out_beat i_beat,
    output logic                    o_not_full,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output bms_pkg::t_out_beat      o_beat
);
    import bms_pkg::*;

    t_out_beat  r_slot [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign o_valid    = (r_count != 2'd0);
    assign o_not_full = (r_count != 2'd2);
    assign o_beat     = r_slot[r_rptr];
    assign pop        = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/buzzer_melody_sequencer_core.sv */
`default_nettype none

// Buzzer melody sequencer.
// Input channel (i_in_valid / o_in_ready / i_in_beat): one beat per timer tick,
// carrying now_ms and the bell button, bell request and alarm request flags.
// Output channel (o_out_valid / i_out_ready / o_out_beat): one beat per input
// beat, giving tone_on, tone_hz and tone_changed, in input order.
// Each result goes into a two-entry result buffer as its input beat is accepted.
// Throughput: one beat per cycle while the buffer has a free slot. The whole
// tick update (elapsed-time compare, note/pattern/repeat advance, tone select)
// is one combinational pass from the sequencer state registers to that buffer.
// Stall: the result buffer holds two beats; input is accepted as long as one
// slot is free, so a single stalled result does not block the next tick.
// Reset (i_rst_n, synchronous, active low): both modes idle, counters clear,
// last tone silent at 0 Hz, result buffer empty, registers to their defaults.
// Config: APB port, registers at 4-byte steps; pready is tied high. Write only
// while no beats are in flight.
module buzzer_melody_sequencer_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // tick input
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire bms_pkg::t_in_beat           i_in_beat,
    // tone output
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output bms_pkg::t_out_beat               o_out_beat,
    // APB config
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bms_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [bms_pkg::DATA_W-1:0]  pwdata,
    output logic      [bms_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);
    import bms_pkg::*;

    t_cfg      cfg;
    t_out_beat result;
    logic      buf_not_full;
    logic      accept;

    // space in the result buffer is the only thing gating input
    assign o_in_ready = buf_not_full;
    assign accept     = i_in_valid && buf_not_full;

    bms_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer state and per-tick update
    bms_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_beat (i_in_beat),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    // result register with one spare slot
    bms_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_beat     (result),
        .o_not_full (buf_not_full),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_beat     (o_out_beat)
    );

endmodule

`default_nettype wire

/* verif/melody_tone_checker.sv */
// Watches the tick and tone channels and the APB write strobe, keeps its own
// model of the sequencer, and compares every tone beat with the oldest
// predicted one.
module melody_tone_checker
    import bms_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  t_in_beat                 i_in_beat,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  t_out_beat                i_out_beat,
    input  wire logic                i_psel,
    input  wire logic                i_penable,
    input  wire logic                i_pwrite,
    input  wire logic                i_pready,
    input  wire logic [ADDR_W-1:0]   i_paddr,
    input  wire logic [DATA_W-1:0]   i_pwdata,
    output int                       o_fail_count,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 200;

    // register copy
    logic [15:0] cfg_beep;
    logic [7:0]  cfg_alarm_passes;
    logic [7:0]  cfg_ring_passes;
    logic [15:0] cfg_note [4];

    // sequencer copy; both modes share the counters
    logic        ring_on;
    logic        alarm_on;
    logic [31:0] seg_start;
    logic [7:0]  step_idx;
    logic [7:0]  pat_sel;
    logic [7:0]  pass_cnt;
    logic        prev_on;
    logic [15:0] prev_hz;

    t_out_beat   tone_queue [$];
    int          fail_cnt = 0;
    int          reports = 0;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic void restart_tune(input logic [31:0] now);
        seg_start = now;
        step_idx = '0;
        pat_sel = '0;
        pass_cnt = '0;
    endfunction

    function automatic t_out_beat predict_tone(input t_in_beat beat);
        t_out_beat   res;
        logic        on;
        logic [15:0] hz;
        logic [31:0] elapsed;
        logic [31:0] len_ms;
        logic [7:0]  notes_in_pat;
        on = 1'b0;
        hz = '0;
        if (beat.alarm_request) begin
            if (!alarm_on) begin
                alarm_on = 1'b1;
                restart_tune(beat.now_ms);
            end
            elapsed = beat.now_ms - seg_start;
            notes_in_pat = (pat_sel == 0) ? 8'd4 : 8'd8;
            if (step_idx >= notes_in_pat || pass_cnt >= cfg_alarm_passes || pat_sel >= 2) begin
                // patterns used up: steady beep
                on = 1'b1;
                hz = cfg_beep;
            end else begin
                if (pat_sel == 0)
                    len_ms = (step_idx == 3) ? DUR_PAT0_GAP : DUR_BEEP;
                else
                    len_ms = (step_idx == 7) ? DUR_PAT1_GAP : DUR_BEEP;
                if (elapsed > len_ms) begin
                    step_idx = step_idx + 8'd1;
                    seg_start = beat.now_ms;
                    if (step_idx >= notes_in_pat) begin
                        step_idx = '0;
                        pass_cnt = pass_cnt + 8'd1;
                        if (pass_cnt >= cfg_alarm_passes) begin
                            pat_sel = pat_sel + 8'd1;
                            pass_cnt = '0;
                        end
                    end
                end
                // even steps beep, odd steps are gaps
                on = ~step_idx[0];
                hz = on ? cfg_beep : 16'd0;
            end
        end else if (beat.bell_button || beat.bell_request) begin
            if (!ring_on) begin
                ring_on = 1'b1;
                restart_tune(beat.now_ms);
            end
            elapsed = beat.now_ms - seg_start;
            if (step_idx < 4 && pass_cnt < cfg_ring_passes) begin
                len_ms = step_idx[0] ? DUR_RING_SHORT : DUR_RING_LONG;
                if (elapsed > len_ms) begin
                    step_idx = step_idx + 8'd1;
                    seg_start = beat.now_ms;
                    if (step_idx >= 4) begin
                        step_idx = '0;
                        pass_cnt = pass_cnt + 8'd1;
                    end
                end
                if (pass_cnt < cfg_ring_passes) begin
                    on = 1'b1;
                    hz = cfg_note[step_idx[1:0]];
                end
            end
        end else begin
            ring_on = 1'b0;
            alarm_on = 1'b0;
        end
        res.tone_on = on;
        res.tone_hz = hz;
        res.tone_changed = (on != prev_on) || (hz != prev_hz);
        prev_on = on;
        prev_hz = hz;
        return res;
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            fail_cnt++;
            if (reports < MAX_REPORTS)
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            reports++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            cfg_beep = RST_BEEP_HZ;
            cfg_alarm_passes = RST_ALARM_REPEATS;
            cfg_ring_passes = RST_RING_REPEATS;
            cfg_note[0] = RST_RING_NOTE_A;
            cfg_note[1] = RST_RING_NOTE_B;
            cfg_note[2] = RST_RING_NOTE_C;
            cfg_note[3] = RST_RING_NOTE_D;
            ring_on = 1'b0;
            alarm_on = 1'b0;
            restart_tune('0);
            prev_on = 1'b0;
            prev_hz = '0;
            tone_queue.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_BEEP_HZ:       cfg_beep = i_pwdata[15:0];
                    REG_ALARM_REPEATS: cfg_alarm_passes = i_pwdata[7:0];
                    REG_RING_REPEATS:  cfg_ring_passes = i_pwdata[7:0];
                    REG_RING_NOTE_A:   cfg_note[0] = i_pwdata[15:0];
                    REG_RING_NOTE_B:   cfg_note[1] = i_pwdata[15:0];
                    REG_RING_NOTE_C:   cfg_note[2] = i_pwdata[15:0];
                    REG_RING_NOTE_D:   cfg_note[3] = i_pwdata[15:0];
                    default: ;
                endcase
            end
            // pop before push so a stray beat cannot eat a fresh prediction
            if (i_out_valid && i_out_ready) begin
                if (tone_queue.size() == 0) begin
                    fail_cnt++;
                    if (reports < MAX_REPORTS)
                        $display("%0t: tone beat with none expected: on=%0d hz=%0d chg=%0d",
                                 $time, i_out_beat.tone_on, i_out_beat.tone_hz,
                                 i_out_beat.tone_changed);
                    reports++;
                end else begin
                    want = tone_queue.pop_front();
                    check_field("tone_on", want.tone_on, i_out_beat.tone_on);
                    check_field("tone_hz", want.tone_hz, i_out_beat.tone_hz);
                    check_field("tone_changed", want.tone_changed, i_out_beat.tone_changed);
                end
            end
            if (i_in_valid && i_in_ready)
                tone_queue.push_back(predict_tone(i_in_beat));
        end
        o_fail_count <= fail_cnt;
        o_pending <= tone_queue.size();
    end

endmodule

/* verif/buzzer_melody_sequencer_core_test.sv */
// Top of the sequencer bench: drives ticks and register writes, stalls the
// tone side, and gives the verdict. All checking sits in the checker.
module buzzer_melody_sequencer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bms_pkg::*;

    localparam int CYCLE_LIMIT = 400000;  // far above the slowest legal run
    localparam int PHASES      = 6;
    localparam int PHASE_TICKS = 290;     // 1740 random ticks in total
    localparam int LONG_HOLD   = 250;     // cycles of the long tone-side hold-off

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_ready;
    t_in_beat          in_beat = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_beat         out_beat;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                fail_count;
    int                pending;

    // sender state
    logic [31:0]       clock_ms = '0;  // running millisecond time of the ticks
    int                tx_gap_max = 18;
    int                phase_items = 0;

    // receiver state
    int                rx_wait = 1;
    int                rx_beats = 0;
    int                rx_max = 18;

    int                cycles = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    buzzer_melody_sequencer_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    melody_tone_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_beat   (out_beat),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Tone side. After each beat it draws a random stall up to its current maximum;
    // every 64 beats it may switch to a no-stall stretch. Twice in the run it holds
    // off for a long stretch so the result buffer fills and the tick side
    // sees o_in_ready drop.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_wait = 1;
        end else if (out_ready && out_valid) begin
            rx_beats++;
            if (rx_beats % 64 == 0)
                rx_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
            if (rx_beats == 500 || rx_beats == 1300)
                rx_wait = LONG_HOLD;
            else
                rx_wait = $urandom_range(0, rx_max);
            if (rx_wait != 0)
                out_ready <= 1'b0;
        end else if (!out_ready) begin
            if (rx_wait > 0)
                rx_wait--;
            if (rx_wait == 0)
                out_ready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // One APB write: setup cycle, then access cycle. The register takes the
    // value at the edge that ends the access cycle.
    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offer one tick, hold it until accepted, then draw the gap to the next.
    // With a zero gap valid simply stays high for the next call.
    task automatic send_tick(input logic [31:0] now, input logic btn, input logic req,
                             input logic alm);
        t_in_beat b;
        int       gap;
        b.now_ms = now;
        b.bell_button = btn;
        b.bell_request = req;
        b.alarm_request = alm;
        in_beat <= b;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        phase_items++;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every predicted tone has come out, plus a margin.
    task automatic drain_tones();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    // Frequencies: the extremes now and then, otherwise anything. Upper
    // bits of pwdata are junk the block must ignore.
    function automatic logic [DATA_W-1:0] pick_hz();
        logic [31:0] junk;
        logic [15:0] hz;
        int          r;
        junk = $urandom;
        r = $urandom_range(0, 9);
        if (r == 0)
            hz = 16'd0;
        else if (r == 1)
            hz = 16'hFFFF;
        else
            hz = 16'($urandom_range(0, 65535));
        return {junk[31:16], hz};
    endfunction

    // Repeat counts: mostly small so the patterns run to their end.
    function automatic logic [DATA_W-1:0] pick_passes();
        logic [31:0] junk;
        logic [7:0]  n;
        int          r;
        junk = $urandom;
        r = $urandom_range(0, 11);
        if (r == 0)
            n = 8'd0;
        else if (r == 1)
            n = 8'd255;
        else if (r <= 3)
            n = 8'd1;
        else
            n = 8'($urandom_range(1, 4));
        return {junk[31:8], n};
    endfunction

    task automatic apply_setting();
        drain_tones();
        write_reg(REG_BEEP_HZ, pick_hz());
        write_reg(REG_ALARM_REPEATS, pick_passes());
        write_reg(REG_RING_REPEATS, pick_passes());
        write_reg(REG_RING_NOTE_A, pick_hz());
        write_reg(REG_RING_NOTE_B, pick_hz());
        write_reg(REG_RING_NOTE_C, pick_hz());
        write_reg(REG_RING_NOTE_D, pick_hz());
    endtask

    // Time step between ticks: mostly short, sometimes long, rarely huge
    // so that elapsed time wraps.
    function automatic logic [31:0] pick_step(input int max_ms);
        int r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return $urandom_range(0, max_ms);
        else if (r < 98)
            return $urandom_range(0, 1000);
        else
            return $urandom;
    endfunction

    // One stretch of ticks. Alarm and bell runs hold the request steady so
    // the patterns get deep; idle runs clear the modes; noise mixes flags
    // and jumps the clock. Runs follow each other without a forced idle,
    // so a mode can pick up counters the other one left behind.
    task automatic run_segment();
        int         kind;
        int         len;
        logic [2:0] flags;  // {bell_button, bell_request, alarm_request}
        kind = $urandom_range(0, 99);
        tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
        if ($urandom_range(0, 19) == 0)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 600);
        if (kind < 35)
            len = $urandom_range(30, 200);
        else if (kind < 65)
            len = $urandom_range(10, 90);
        else if (kind < 80)
            len = $urandom_range(1, 4);
        else
            len = $urandom_range(4, 24);
        // the phase budget cuts the last stretch short
        for (int i = 0; i < len && phase_items < PHASE_TICKS; i++) begin
            if (kind < 35) begin
                clock_ms += pick_step(80);
                flags = {2'($urandom_range(0, 3)), 1'b1};
            end else if (kind < 65) begin
                clock_ms += pick_step(25);
                flags = {2'($urandom_range(1, 3)), 1'b0};
            end else if (kind < 80) begin
                clock_ms += pick_step(100);
                flags = 3'b000;
            end else begin
                if ($urandom_range(0, 3) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms += pick_step(60);
                flags = 3'($urandom_range(0, 7));
            end
            // the odd broken tick inside a steady run
            if (kind < 65 && $urandom_range(0, 32) == 0)
                flags = 3'($urandom_range(0, 7));
            send_tick(clock_ms, flags[2], flags[1], flags[0]);
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Full-scale beep, single passes, extreme notes.
        write_reg(REG_BEEP_HZ, 32'h0000_FFFF);
        write_reg(REG_ALARM_REPEATS, 32'd1);
        write_reg(REG_RING_REPEATS, 32'd1);
        write_reg(REG_RING_NOTE_A, 32'd0);
        write_reg(REG_RING_NOTE_B, 32'hFFFF_FFFF);
        write_reg(REG_RING_NOTE_C, 32'd21845);
        write_reg(REG_RING_NOTE_D, 32'd43690);

        send_tick(32'd0, 1'b0, 1'b0, 1'b0);     // silent, nothing changed
        send_tick(32'd100, 1'b1, 1'b0, 1'b0);   // bell starts on note A
        send_tick(32'd130, 1'b1, 1'b0, 1'b0);   // elapsed equals 30: no advance
        send_tick(32'd131, 1'b1, 1'b0, 1'b0);   // 31 > 30: note B
        send_tick(32'd141, 1'b0, 1'b1, 1'b0);   // software request keeps bell
        send_tick(32'd142, 1'b0, 1'b1, 1'b0);   // note C
        send_tick(32'd173, 1'b1, 1'b1, 1'b0);   // note D
        send_tick(32'd184, 1'b1, 1'b0, 1'b0);   // one pass done: silence
        send_tick(32'd185, 1'b1, 1'b0, 1'b0);
        send_tick(32'd200, 1'b0, 1'b0, 1'b1);   // alarm wins, starts beeping
        send_tick(32'd240, 1'b0, 1'b0, 1'b1);
        send_tick(32'd241, 1'b0, 1'b0, 1'b1);   // first gap
        send_tick(32'd282, 1'b0, 1'b0, 1'b1);
        send_tick(32'd323, 1'b0, 1'b0, 1'b1);   // long gap of the two-beep pattern
        send_tick(32'd1164, 1'b1, 1'b0, 1'b1);  // into the four-beep pattern
        send_tick(32'hFFFF_FFF0, 1'b0, 1'b0, 1'b1);
        send_tick(32'd5, 1'b0, 1'b1, 1'b1);     // time wrapped
        send_tick(32'd10, 1'b0, 1'b1, 1'b0);    // bell resumes on alarm counters
        send_tick(32'd6, 1'b0, 1'b0, 1'b0);     // modes clear
        send_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        send_tick(32'd0, 1'b0, 1'b0, 1'b0);

        // Zero repeat registers and a zero beep tone.
        drain_tones();
        write_reg(REG_BEEP_HZ, 32'd0);
        write_reg(REG_ALARM_REPEATS, 32'd0);
        write_reg(REG_RING_REPEATS, 32'd0);
        send_tick(32'd10, 1'b0, 1'b0, 1'b1);    // steady beep at 0 Hz
        send_tick(32'd20, 1'b0, 1'b0, 1'b0);
        send_tick(32'd30, 1'b1, 1'b0, 1'b0);    // bell silent at once
        send_tick(32'd40, 1'b0, 1'b1, 1'b0);

        // Random part: a fresh register setting per phase.
        for (int p = 0; p < PHASES; p++) begin
            apply_setting();
            phase_items = 0;
            while (phase_items < PHASE_TICKS)
                run_segment();
        end

        drain_tones();
        repeat (6) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* buzzer_melody_sequencer_core.f */
rtl/bms_pkg.sv
rtl/bms_cfg_regs.sv
rtl/bms_step.sv
rtl/bms_out_buf.sv
rtl/buzzer_melody_sequencer_core.sv
verif/melody_tone_checker.sv
verif/buzzer_melody_sequencer_core_test.sv
